[src/csvfs_pkg.sv]
// Package for the CSV field splitter: parse modes, quote bytes, warning codes
// and the item and result structures shared by all modules. No dependencies.
package csvfs_pkg;

  typedef enum logic [2:0] {
    MODE_LINE_START  = 3'd0,
    MODE_FIELD_START = 3'd1,
    MODE_UNQUOTED    = 3'd2,
    MODE_QUOTED      = 3'd3,
    MODE_AFTER_QUOTE = 3'd4,
    MODE_SKIP        = 3'd5
  } mode_t;

  localparam logic [7:0] DQUOTE_BYTE = 8'h22;
  localparam logic [7:0] SQUOTE_BYTE = 8'h27;
  localparam logic [7:0] SEP_RESET   = 8'd44;

  localparam logic [1:0] WARN_NONE     = 2'd0;
  localparam logic [1:0] WARN_EMPTY    = 2'd1;
  localparam logic [1:0] WARN_NO_SEP   = 2'd2;
  localparam logic [1:0] WARN_UNCLOSED = 2'd3;

  localparam logic [1:0] ENDED_NONE = 2'd0;
  localparam logic [1:0] ENDED_ONE  = 2'd1;
  localparam logic [1:0] ENDED_TWO  = 2'd2;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       no_byte;
    logic       line_end;
  } item_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       char_valid;
    logic [1:0] fields_ended;
    logic       field_void;
    logic       line_done;
    logic [1:0] warning_code;
  } result_t;

endpackage

[src/csv_field_splitter.sv]
// Top level of the CSV field splitter. An accepted input transaction moves
// from the input register to the result register; one item is taken every
// cycle while out_stall is low, as set by those two registers with the parse
// logic between them. Reset is synchronous and active low: it sets the
// separator to a comma, the parse mode to line start and empties both stages.
module csv_field_splitter (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte_in,
  input  logic       in_no_byte,
  input  logic       in_line_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char_out,
  output logic       out_char_valid,
  output logic [1:0] out_fields_ended,
  output logic       out_field_void,
  output logic       out_line_done,
  output logic [1:0] out_warning_code,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_separator_byte
);
  import csvfs_pkg::*;

  logic [7:0] sep_r, sep_nxt;
  item_t      in_item, s1_item;
  logic       s1_vld, take;
  result_t    core_res, out_res;
  mode_t      core_mode;

  assign cfg_ready = 1'b1;
  assign sep_nxt   = (cfg_valid && cfg_ready) ? cfg_separator_byte : sep_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_r <= SEP_RESET;
    end else begin
      sep_r <= sep_nxt;
    end
  end

  assign in_item.byte_in  = in_byte_in;
  assign in_item.no_byte  = in_no_byte;
  assign in_item.line_end = in_line_end;

  csvfs_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .item_i   (in_item),
    .take     (take),
    .vld_o    (s1_vld),
    .item_o   (s1_item)
  );

  csvfs_parse_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (take),
    .item_i  (s1_item),
    .sep_i   (sep_r),
    .res_o   (core_res),
    .mode_o  (core_mode)
  );

  csvfs_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .vld_i     (s1_vld),
    .res_i     (core_res),
    .take      (take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res_o     (out_res)
  );

  assign out_char_out     = out_res.char_out;
  assign out_char_valid   = out_res.char_valid;
  assign out_fields_ended = out_res.fields_ended;
  assign out_field_void   = out_res.field_void;
  assign out_line_done    = out_res.line_done;
  assign out_warning_code = out_res.warning_code;

  // A transaction that ends the line leaves the parser at line start.
  a_line_end_resets_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (take && s1_item.line_end) |=> (core_mode == MODE_LINE_START))
    else $error("parse mode not at line start after line end");

  a_two_fields_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_fields_ended == ENDED_TWO) |->
      (out_warning_code == WARN_EMPTY && out_line_done && !out_char_valid))
    else $error("two fields closed without an empty field at line end");

  a_void_unclosed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_field_void) |->
      (out_warning_code == WARN_UNCLOSED && out_line_done &&
       out_fields_ended == ENDED_ONE))
    else $error("voided field without unclosed quote at line end");

  a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_char_valid) |-> (out_char_out == 8'd0))
    else $error("character output not zero without a character");
endmodule

[src/csvfs_in_reg.sv]
// Input register of the CSV field splitter: holds one accepted transaction
// until the parse stage takes it. Depends on csvfs_pkg.
module csvfs_in_reg (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  csvfs_pkg::item_t item_i,
  input  logic            take,
  output logic            vld_o,
  output csvfs_pkg::item_t item_o
);
  import csvfs_pkg::*;

  logic  vld_r, vld_nxt;
  item_t item_r;
  logic  load;

  assign in_stall = vld_r & ~take;
  assign load     = in_valid & ~in_stall;
  assign vld_nxt  = load | (vld_r & ~take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= item_i;
    end
  end

  assign vld_o  = vld_r;
  assign item_o = item_r;
endmodule

[src/csvfs_parse_core.sv]
// Parse stage of the CSV field splitter: parse mode and quote kind registers
// and the per-byte decision logic. Depends on csvfs_pkg.
module csvfs_parse_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               advance,
  input  csvfs_pkg::item_t   item_i,
  input  logic [7:0]         sep_i,
  output csvfs_pkg::result_t res_o,
  output csvfs_pkg::mode_t   mode_o
);
  import csvfs_pkg::*;

  mode_t   mode_r, mode_nxt;
  logic    qsingle_r, qsingle_nxt;
  result_t res;
  logic    is_sep, is_quote, last;
  mode_t   mode_c;
  logic    qsingle_c;

  always_comb begin
    last      = item_i.line_end;
    is_sep    = (item_i.byte_in == sep_i);
    is_quote  = (item_i.byte_in == DQUOTE_BYTE) || (item_i.byte_in == SQUOTE_BYTE);
    res       = '0;
    res.line_done = last;
    mode_c    = mode_r;
    qsingle_c = qsingle_r;
    if (item_i.no_byte) begin
      if (last) begin
        if (mode_r == MODE_LINE_START || mode_r == MODE_UNQUOTED) begin
          res.fields_ended = ENDED_ONE;
        end else if (mode_r == MODE_QUOTED) begin
          res.fields_ended = ENDED_ONE;
          res.field_void   = 1'b1;
          res.warning_code = WARN_UNCLOSED;
        end
      end
    end else begin
      case (mode_r)
        MODE_LINE_START, MODE_FIELD_START: begin
          if (is_quote) begin
            qsingle_c = (item_i.byte_in == SQUOTE_BYTE);
            mode_c    = MODE_QUOTED;
            if (last) begin
              res.fields_ended = ENDED_ONE;
              res.field_void   = 1'b1;
              res.warning_code = WARN_UNCLOSED;
            end
          end else if (is_sep) begin
            res.fields_ended = last ? ENDED_TWO : ENDED_ONE;
            res.warning_code = WARN_EMPTY;
            mode_c = MODE_FIELD_START;
          end else begin
            res.char_out   = item_i.byte_in;
            res.char_valid = 1'b1;
            mode_c = MODE_UNQUOTED;
            if (last) begin
              res.fields_ended = ENDED_ONE;
            end
          end
        end
        MODE_UNQUOTED: begin
          if (is_sep) begin
            res.fields_ended = ENDED_ONE;
            mode_c = MODE_FIELD_START;
          end else begin
            res.char_out   = item_i.byte_in;
            res.char_valid = 1'b1;
            if (last) begin
              res.fields_ended = ENDED_ONE;
            end
          end
        end
        MODE_QUOTED: begin
          if (item_i.byte_in == (qsingle_r ? SQUOTE_BYTE : DQUOTE_BYTE)) begin
            res.fields_ended = ENDED_ONE;
            mode_c = MODE_AFTER_QUOTE;
          end else begin
            res.char_out   = item_i.byte_in;
            res.char_valid = 1'b1;
            if (last) begin
              res.fields_ended = ENDED_ONE;
              res.field_void   = 1'b1;
              res.warning_code = WARN_UNCLOSED;
            end
          end
        end
        MODE_AFTER_QUOTE: begin
          if (is_sep) begin
            mode_c = MODE_FIELD_START;
          end else begin
            res.warning_code = WARN_NO_SEP;
            mode_c = MODE_SKIP;
          end
        end
        default: begin
          mode_c = is_sep ? MODE_FIELD_START : MODE_SKIP;
        end
      endcase
    end
    if (last) begin
      mode_c    = MODE_LINE_START;
      qsingle_c = 1'b0;
    end
    mode_nxt    = advance ? mode_c : mode_r;
    qsingle_nxt = advance ? qsingle_c : qsingle_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_LINE_START;
      qsingle_r <= 1'b0;
    end else begin
      mode_r    <= mode_nxt;
      qsingle_r <= qsingle_nxt;
    end
  end

  assign res_o  = res;
  assign mode_o = mode_r;
endmodule

[src/csvfs_out_reg.sv]
// Result register of the CSV field splitter: holds one result transaction
// until the receiver takes it. Depends on csvfs_pkg.
module csvfs_out_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               vld_i,
  input  csvfs_pkg::result_t res_i,
  output logic               take,
  output logic               out_valid,
  input  logic               out_stall,
  output csvfs_pkg::result_t res_o
);
  import csvfs_pkg::*;

  logic    vld_r, vld_nxt;
  result_t res_r;

  assign take    = vld_i & (~vld_r | ~out_stall);
  assign vld_nxt = take | (vld_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res_i;
    end
  end

  assign out_valid = vld_r;
  assign res_o     = res_r;
endmodule
